@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the deframer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/tfda_pkg.sv @@
// Shared constants and types of the typed frame deframer.
package tfda_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
  localparam int MIN_LEN_W    = 27;
  localparam int MAX_LEN_W    = 31;
  localparam int POS_W        = 31;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 32;

  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = MIN_LEN_W'(10);
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(67108864);
  localparam logic [16:0]          ADLER_MOD     = 17'd65521;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    RGN_LENGTH   = 3'd0,
    RGN_NAME_LEN = 3'd1,
    RGN_NAME     = 3'd2,
    RGN_NAME_NUL = 3'd3,
    RGN_PAYLOAD  = 3'd4,
    RGN_CHECKSUM = 3'd5,
    RGN_DROP     = 3'd6
  } region_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_CKSUM    = 2'd2,
    ST_BAD_NAME = 2'd3
  } status_t;

  typedef struct packed {
    logic step;
    logic clear;
  } adler_ctl_t;

endpackage

@@ hw/rtl/tfda_if.sv @@
// Channel interfaces: byte input, tagged byte output, register writes.
interface tfda_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tfda_out_if;
  import tfda_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  region_t    region;
  logic       frame_end;
  status_t    frame_status;
  modport source (output valid, output out_byte, output region, output frame_end,
                  output frame_status, input ready);
  modport sink   (input valid, input out_byte, input region, input frame_end,
                  input frame_status, output ready);
endinterface

interface tfda_cfg_if;
  import tfda_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/typed_frame_deframer_adler32_core.sv @@
// Top level: deframes length-prefixed typed frames and checks their Adler-32.
// Each input transaction passes through the input register, then the result register.
// Throughput: one byte per cycle while the output is ready; the Adler-32 update is two modular adds per byte.
// Every accepted byte yields exactly one result transaction, in order.
// Reset (rst_n low, synchronous): length-field phase, checksum seeded to 1,
// registers back to min 10 / max 67108864, both pipeline stages empty.
module typed_frame_deframer_adler32_core (
  input  logic       clk,
  input  logic       rst_n,
  tfda_in_if.sink    in_chan,
  tfda_out_if.source out_chan,
  tfda_cfg_if.sink   cfg_chan
);
  import tfda_pkg::*;
`include "assert_macros.svh"

  // Frame sequencer: header length field, body, or halted after an error.
  typedef enum logic [2:0] {
    S_LENGTH = 3'b001,
    S_BODY   = 3'b010,
    S_HALT   = 3'b100
  } state_t;

  // Configuration registers.
  logic [MIN_LEN_W-1:0] min_len_r;
  logic [MAX_LEN_W-1:0] max_len_r;

  // Input register stage.
  logic       s1_v_r;
  logic [7:0] s1_byte_r;

  // Result register stage.
  logic       out_v_r;
  logic [7:0] out_byte_r;
  region_t    out_region_r;
  logic       out_end_r;
  status_t    out_status_r;

  // Frame state.
  state_t               state_r, state_nxt;
  logic [HDR_CNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [23:0]          flen_r, flen_nxt;     // length field shift, top bytes
  logic [23:0]          nlen_r, nlen_nxt;     // name length shift, top bytes
  logic [23:0]          exp_r, exp_nxt;       // received checksum shift, top bytes
  logic [POS_W-1:0]     ck_start_r, ck_start_nxt;
  logic [POS_W-1:0]     last_r, last_nxt;
  logic [POS_W-1:0]     nul_pos_r, nul_pos_nxt;
  logic                 name_ok_r, name_ok_nxt;

  logic       advance;
  logic       proc;
  region_t    rgn;
  logic       fend;
  status_t    fstat;
  adler_ctl_t actl;
  logic [15:0] sum_low, sum_high;

  logic [31:0] len_full;
  logic [31:0] nlen_full;
  logic [31:0] exp_full;
  logic        len_bad;

  // Handshakes: the result register frees up when empty or being taken;
  // the input register refills whenever it moves forward.
  assign advance        = !out_v_r || out_chan.ready;
  assign proc           = s1_v_r && advance;
  assign in_chan.ready  = !s1_v_r || advance;
  assign cfg_chan.ready = 1'b1;

  // Assemble full header words from the held bytes and the current byte.
  assign len_full  = {flen_r, s1_byte_r};
  assign nlen_full = {nlen_r, s1_byte_r};
  assign exp_full  = {exp_r, s1_byte_r};

  // Bad length: negative, shorter than two header fields, or outside min/max.
  assign len_bad = len_full[31]
                || (len_full < 32'(2 * HEADER_BYTES))
                || (len_full < 32'(min_len_r))
                || (len_full > 32'(max_len_r));

  tfda_adler32 u_adler (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (actl),
    .data     (s1_byte_r),
    .sum_low  (sum_low),
    .sum_high (sum_high)
  );

  always_comb begin
    state_nxt    = state_r;
    hcnt_nxt     = hcnt_r;
    pos_nxt      = pos_r;
    flen_nxt     = flen_r;
    nlen_nxt     = nlen_r;
    exp_nxt      = exp_r;
    ck_start_nxt = ck_start_r;
    last_nxt     = last_r;
    nul_pos_nxt  = nul_pos_r;
    name_ok_nxt  = name_ok_r;
    rgn          = RGN_DROP;
    fend         = 1'b0;
    fstat        = ST_OK;
    actl         = '0;

    unique case (state_r)
      S_LENGTH: begin
        rgn      = RGN_LENGTH;
        flen_nxt = len_full[23:0];
        hcnt_nxt = hcnt_r + 1'b1;
        if (hcnt_r == HDR_CNT_W'(HEADER_BYTES - 1)) begin
          hcnt_nxt = '0;
          pos_nxt  = '0;
          // Precompute the body positions used later in the frame.
          ck_start_nxt = len_full[POS_W-1:0] - POS_W'(HEADER_BYTES);
          last_nxt     = len_full[POS_W-1:0] - POS_W'(1);
          if (len_bad) begin
            fend      = 1'b1;
            fstat     = ST_BAD_LEN;
            state_nxt = S_HALT;
          end else begin
            state_nxt = S_BODY;
          end
        end
      end
      S_BODY: begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r < ck_start_r) begin
          actl.step = 1'b1;
          if (pos_r < POS_W'(HEADER_BYTES)) begin
            rgn      = RGN_NAME_LEN;
            nlen_nxt = nlen_full[23:0];
            if (pos_r == POS_W'(HEADER_BYTES - 1)) begin
              // Name length must be 2 .. L - 2*header, nonnegative.
              name_ok_nxt = !nlen_full[31]
                         && (nlen_full >= 32'd2)
                         && (nlen_full[POS_W-1:0] <= ck_start_r - POS_W'(HEADER_BYTES));
              nul_pos_nxt = nlen_full[POS_W-1:0] + POS_W'(HEADER_BYTES - 1);
            end
          end else if (name_ok_r) begin
            if (pos_r < nul_pos_r) begin
              rgn = RGN_NAME;
            end else if (pos_r == nul_pos_r) begin
              rgn = RGN_NAME_NUL;
            end else begin
              rgn = RGN_PAYLOAD;
            end
          end else begin
            rgn = RGN_PAYLOAD;
          end
        end else begin
          rgn     = RGN_CHECKSUM;
          exp_nxt = exp_full[23:0];
          if (pos_r == last_r) begin
            // Close the frame: checksum error outranks bad name length.
            fend       = 1'b1;
            actl.clear = 1'b1;
            hcnt_nxt   = '0;
            if (exp_full != {sum_high, sum_low}) begin
              fstat     = ST_CKSUM;
              state_nxt = S_HALT;
            end else if (!name_ok_r) begin
              fstat     = ST_BAD_NAME;
              state_nxt = S_HALT;
            end else begin
              state_nxt = S_LENGTH;
            end
          end
        end
      end
      S_HALT: begin
        rgn = RGN_DROP;
      end
      default: begin
        rgn = RGN_DROP;
      end
    endcase

    // Hold everything unless a byte actually moves into the result register.
    if (!proc) begin
      state_nxt = state_r;
      actl      = '0;
    end
  end

  // Configuration writes; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_MIN_FRAME_LEN: min_len_r <= cfg_chan.data[MIN_LEN_W-1:0];
        CFG_MAX_FRAME_LEN: max_len_r <= cfg_chan.data[MAX_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= S_LENGTH;
      hcnt_r  <= '0;
      pos_r   <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= s1_v_r;
      end
      state_r <= state_nxt;
      if (proc) begin
        hcnt_r <= hcnt_nxt;
        pos_r  <= pos_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.in_byte;
    end
    if (proc) begin
      flen_r       <= flen_nxt;
      nlen_r       <= nlen_nxt;
      exp_r        <= exp_nxt;
      ck_start_r   <= ck_start_nxt;
      last_r       <= last_nxt;
      nul_pos_r    <= nul_pos_nxt;
      name_ok_r    <= name_ok_nxt;
      out_byte_r   <= s1_byte_r;
      out_region_r <= rgn;
      out_end_r    <= fend;
      out_status_r <= fstat;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.out_byte     = out_byte_r;
  assign out_chan.region       = out_region_r;
  assign out_chan.frame_end    = out_end_r;
  assign out_chan.frame_status = out_status_r;

  // A nonzero status only ever rides on a frame end.
  `ASSERT_IMPLIES(a_status_at_end, clk, rst_n, out_v_r && (out_status_r != ST_OK), out_end_r)
  // Once halted, stay halted until reset.
  `ASSERT_NEXT(a_halt_sticky, clk, rst_n, state_r == S_HALT, state_r == S_HALT)
  // A byte processed while halted comes out as dropped.
  `ASSERT_NEXT(a_halt_drops, clk, rst_n, proc && (state_r == S_HALT), out_region_r == RGN_DROP)
  // The low checksum half stays reduced.
  `ASSERT_IMPLIES(a_adler_low_range, clk, rst_n, 1'b1, {1'b0, sum_low} < ADLER_MOD)

endmodule

@@ hw/rtl/tfda_adler32.sv @@
// Running Adler-32 accumulator, one byte per step.
module tfda_adler32 (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tfda_pkg::adler_ctl_t ctl,
  input  logic [7:0]           data,
  output logic [15:0]          sum_low,
  output logic [15:0]          sum_high
);
  import tfda_pkg::*;

  logic [15:0] low_r, low_nxt;
  logic [15:0] high_r, high_nxt;
  logic [16:0] low_add, high_add;

  always_comb begin
    low_add  = {1'b0, low_r} + {9'd0, data};
    low_nxt  = (low_add >= ADLER_MOD) ? 16'(low_add - ADLER_MOD) : low_add[15:0];
    high_add = {1'b0, high_r} + {1'b0, low_nxt};
    high_nxt = (high_add >= ADLER_MOD) ? 16'(high_add - ADLER_MOD) : high_add[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      low_r  <= 16'd1;
      high_r <= 16'd0;
    end else if (ctl.step) begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  assign sum_low  = low_r;
  assign sum_high = high_r;

endmodule
